@@ hdl/rmf_pkg.sv @@
// Shared types, sizes and the nine-sample median network of the RGB 3x3 median filter.
// No dependencies; rmf_front, rmf_window and the core import this package.
`default_nettype none

package rmf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SAMPLE_BITS = 8;

    localparam int PIX_BITS    = 3 * SAMPLE_BITS;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int ROW_BITS    = 13;
    localparam int CNT_BITS    = 22;
    localparam int WH_BITS     = WIDTH_BITS + HEIGHT_BITS;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = HEIGHT_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [PIX_BITS-1:0]    pix_t;
    typedef sample_t [8:0]          nine_t;

    typedef struct packed {
        logic [COL_BITS-1:0] addr;
        logic                gate_upper;
        logic                gate_middle;
        logic                give;
        logic                col_zero;
        logic                col_ge2;
        logic                wide;
        logic                last;
        pix_t                pix;
    } item_t;

    localparam int NET_STEPS = 19;
    localparam int NET_LO [NET_STEPS] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
    localparam int NET_HI [NET_STEPS] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

    function automatic sample_t median9(input nine_t v);
        nine_t   p;
        sample_t t;
        p = v;
        for (int i = 0; i < NET_STEPS; i++)
        begin
            if (p[NET_LO[i]] > p[NET_HI[i]])
            begin
                t            = p[NET_LO[i]];
                p[NET_LO[i]] = p[NET_HI[i]];
                p[NET_HI[i]] = t;
            end
        end
        return p[4];
    endfunction

endpackage

`default_nettype wire

@@ hdl/rmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rmf_ram #(
    parameter int DATA_BITS = 24,
    parameter int DEPTH     = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0]     wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_BITS-1:0]     rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/rmf_front.sv @@
// Input side of the median filter: frame size registers, raster position, result count
// and the input register. Depends on rmf_pkg.
`default_nettype none

module rmf_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rmf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rmf_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire rmf_pkg::sample_t                  in_red,
    input  wire rmf_pkg::sample_t                  in_green,
    input  wire rmf_pkg::sample_t                  in_blue,
    input  wire logic                              item_done,
    output rmf_pkg::item_t                         item,
    output logic                                   item_valid,
    output logic                                   load,
    output logic [rmf_pkg::COL_BITS-1:0]           load_addr
);

    import rmf_pkg::*;

    logic [WIDTH_BITS-1:0]  width_reg, width_next;
    logic [HEIGHT_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    item_t                  item_reg, item_next;
    logic                   item_valid_reg, item_valid_next;

    logic                   accept;
    logic                   active;
    logic                   give;
    logic                   last;
    logic                   in_frame;
    logic [CNT_BITS-1:0]    count_inc;
    logic [WH_BITS-1:0]     frame_size;
    logic [WIDTH_BITS-1:0]  col_plus;
    logic [WIDTH_BITS-1:0]  width_raw;

    always_comb
    begin
        in_ready   = !item_valid_reg || item_done;
        accept     = in_valid && in_ready;
        in_frame   = ROW_BITS'(row_reg) < ROW_BITS'(height_reg);
        active     = !(req_type && in_frame);
        load       = accept && active;
        load_addr  = col_reg;
        give       = (row_reg >= ROW_BITS'(2)) || ((row_reg == ROW_BITS'(1)) && (col_reg != '0));
        count_inc  = count_reg + CNT_BITS'(1);
        frame_size = WH_BITS'(width_reg) * WH_BITS'(height_reg);
        last       = give && (WH_BITS'(count_inc) >= frame_size);
        col_plus   = WIDTH_BITS'(col_reg) + WIDTH_BITS'(1);
        width_raw  = cfg_data[WIDTH_BITS-1:0];
    end

    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        count_next      = count_reg;
        item_next       = item_reg;
        item_valid_next = item_valid_reg;

        if (item_done)
        begin
            item_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IDX_WIDTH:
                begin
                    if (width_raw == '0)
                    begin
                        width_next = WIDTH_BITS'(1);
                    end
                    else if (width_raw > WIDTH_BITS'(MAX_WIDTH))
                    begin
                        width_next = WIDTH_BITS'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = width_raw;
                    end
                    col_next   = '0;
                    row_next   = '0;
                    count_next = '0;
                end
                CFG_IDX_HEIGHT:
                begin
                    if (cfg_data == '0)
                    begin
                        height_next = HEIGHT_BITS'(1);
                    end
                    else if (cfg_data > HEIGHT_BITS'(MAX_HEIGHT))
                    begin
                        height_next = HEIGHT_BITS'(MAX_HEIGHT);
                    end
                    else
                    begin
                        height_next = cfg_data;
                    end
                    col_next   = '0;
                    row_next   = '0;
                    count_next = '0;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
        else if (load)
        begin
            item_valid_next       = 1'b1;
            item_next.addr        = col_reg;
            item_next.gate_upper  = row_reg >= ROW_BITS'(2);
            item_next.gate_middle = row_reg != '0;
            item_next.give        = give;
            item_next.col_zero    = col_reg == '0;
            item_next.col_ge2     = col_reg >= COL_BITS'(2);
            item_next.wide        = width_reg >= WIDTH_BITS'(2);
            item_next.last        = last;
            if (req_type || !in_frame)
            begin
                item_next.pix = '0;
            end
            else
            begin
                item_next.pix = {in_blue, in_green, in_red};
            end

            if (col_plus >= width_reg)
            begin
                col_next = '0;
                row_next = row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_plus[COL_BITS-1:0];
            end

            if (give)
            begin
                count_next = count_inc;
            end

            if (last)
            begin
                col_next   = '0;
                row_next   = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            count_reg      <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            count_reg      <= count_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = item_valid_reg;

endmodule

`default_nettype wire

@@ hdl/rmf_window.sv @@
// Window stage of the median filter: line store write-back with bypass, the 3x3 window,
// the per-channel medians and the output register. Depends on rmf_pkg.
`default_nettype none

module rmf_window (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    clear,
    input  wire rmf_pkg::item_t          item,
    input  wire logic                    item_valid,
    input  wire logic                    load,
    input  wire logic [rmf_pkg::COL_BITS-1:0] load_addr,
    input  wire rmf_pkg::pix_t           upper_rd,
    input  wire rmf_pkg::pix_t           middle_rd,
    output logic                         item_done,
    output logic                         wr_en,
    output logic [rmf_pkg::COL_BITS-1:0] wr_addr,
    output rmf_pkg::pix_t                upper_wr,
    output rmf_pkg::pix_t                middle_wr,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output rmf_pkg::sample_t             out_red,
    output rmf_pkg::sample_t             out_green,
    output rmf_pkg::sample_t             out_blue,
    output logic                         frame_last
);

    import rmf_pkg::*;

    pix_t    win_reg [9];
    pix_t    win_next [9];
    logic    byp_reg, byp_next;
    pix_t    byp_upper_reg, byp_middle_reg;
    logic    out_valid_reg, out_valid_next;
    sample_t med_reg [3];
    sample_t med_next [3];
    logic    last_reg, last_next;

    pix_t    upper_px;
    pix_t    middle_px;
    logic    left_on;
    logic    right_on;
    pix_t    taps [9];
    nine_t   vals [3];

    always_comb
    begin
        item_done = item_valid && (!item.give || !out_valid_reg || out_ready);

        upper_px  = byp_reg ? byp_upper_reg : upper_rd;
        middle_px = byp_reg ? byp_middle_reg : middle_rd;
        if (!item.gate_upper)
        begin
            upper_px = '0;
        end
        if (!item.gate_middle)
        begin
            middle_px = '0;
        end

        wr_en     = item_done;
        wr_addr   = item.addr;
        upper_wr  = middle_px;
        middle_wr = item.pix;

        left_on  = item.col_zero ? item.wide : item.col_ge2;
        right_on = !item.col_zero;

        for (int r = 0; r < 3; r++)
        begin
            taps[r]     = left_on ? win_reg[3 + r] : '0;
            taps[3 + r] = win_reg[6 + r];
        end
        taps[6] = right_on ? upper_px : '0;
        taps[7] = right_on ? middle_px : '0;
        taps[8] = right_on ? item.pix : '0;

        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 9; k++)
            begin
                vals[c][k] = taps[k][c*SAMPLE_BITS +: SAMPLE_BITS];
            end
            med_next[c] = median9(vals[c]);
        end

        for (int k = 0; k < 9; k++)
        begin
            win_next[k] = win_reg[k];
        end
        if (clear)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_next[k] = '0;
            end
        end
        else if (item_done)
        begin
            if (item.give && item.last)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    win_next[k] = '0;
                end
            end
            else
            begin
                for (int k = 0; k < 6; k++)
                begin
                    win_next[k] = win_reg[k + 3];
                end
                win_next[6] = upper_px;
                win_next[7] = middle_px;
                win_next[8] = item.pix;
            end
        end

        byp_next = byp_reg;
        if (load)
        begin
            byp_next = item_done && (load_addr == item.addr);
        end

        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (item_done && item.give)
        begin
            out_valid_next = 1'b1;
            last_next      = item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= win_next[k];
            end
            byp_reg       <= byp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byp_upper_reg  <= middle_px;
            byp_middle_reg <= item.pix;
        end
        if (item_done && item.give)
        begin
            for (int c = 0; c < 3; c++)
            begin
                med_reg[c] <= med_next[c];
            end
        end
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = med_reg[0];
    assign out_green  = med_reg[1];
    assign out_blue   = med_reg[2];
    assign frame_last = last_reg;

endmodule

`default_nettype wire

@@ hdl/rgb_median_3x3_filter_core.sv @@
// RGB 3x3 per-channel median filter, streaming in raster order, zero outside the image.
// Throughput: one request per cycle unless the output stalls; a result passes the input and
// output registers after its request, which follows its centre pixel by one row plus one.
// Reset: asynchronous; frame size returns to 640 x 480, position and window clear at once;
// the line stores hold no reset value and their data is used only once written in the frame.
// Depends on rmf_pkg, rmf_ram, rmf_front and rmf_window.
`default_nettype none

module rgb_median_3x3_filter_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rmf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rmf_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire rmf_pkg::sample_t                  in_red,
    input  wire rmf_pkg::sample_t                  in_green,
    input  wire rmf_pkg::sample_t                  in_blue,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output rmf_pkg::sample_t                       out_red,
    output rmf_pkg::sample_t                       out_green,
    output rmf_pkg::sample_t                       out_blue,
    output logic                                   frame_last
);

    import rmf_pkg::*;

    item_t               item;
    logic                item_valid;
    logic                item_done;
    logic                load;
    logic [COL_BITS-1:0] load_addr;
    logic                wr_en;
    logic [COL_BITS-1:0] wr_addr;
    pix_t                upper_wr, middle_wr;
    pix_t                upper_rd, middle_rd;
    logic                cfg_clear;

    assign cfg_clear = cfg_wr_en && (cfg_index inside {CFG_IDX_WIDTH, CFG_IDX_HEIGHT});

    rmf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .item_done  (item_done),
        .item       (item),
        .item_valid (item_valid),
        .load       (load),
        .load_addr  (load_addr)
    );

    rmf_ram #(
        .DATA_BITS (PIX_BITS),
        .DEPTH     (MAX_WIDTH)
    ) u_upper_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (upper_wr),
        .rd_en   (load),
        .rd_addr (load_addr),
        .rd_data (upper_rd)
    );

    rmf_ram #(
        .DATA_BITS (PIX_BITS),
        .DEPTH     (MAX_WIDTH)
    ) u_middle_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (middle_wr),
        .rd_en   (load),
        .rd_addr (load_addr),
        .rd_data (middle_rd)
    );

    rmf_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (cfg_clear),
        .item       (item),
        .item_valid (item_valid),
        .load       (load),
        .load_addr  (load_addr),
        .upper_rd   (upper_rd),
        .middle_rd  (middle_rd),
        .item_done  (item_done),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .upper_wr   (upper_wr),
        .middle_wr  (middle_wr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire
